FILE: src/lsmf_pkg.sv
package lsmf_pkg;

   // field widths
   localparam int KEY_BITS      = 64;
   localparam int SEQ_BITS      = 56;
   localparam int KIND_BITS     = 3;
   localparam int TAG_BITS      = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 56;
   localparam int CNT_BITS      = 3;

   // snapshot registers present and how many of them may be in use
   localparam int NUM_SNAP_REGS = 4;
   localparam int MAX_SNAPSHOTS = 4;

   // sequence of the tip stripe
   localparam logic [SEQ_BITS-1:0] MAX_SEQ = '1;

   // record kinds
   localparam logic [KIND_BITS-1:0] KIND_VALUE      = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_LARGE      = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DELETE     = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_SINGLE_DEL = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_OTHER      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNAPSHOT_A    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNAPSHOT_B    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNAPSHOT_C    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNAPSHOT_D    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SNAPSHOT_CNT  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONFLICT_SNAP = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEEP_ALL      = 3'd6;

   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [SEQ_BITS-1:0]  seq_type;
   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [TAG_BITS-1:0]  tag_type;

   typedef struct packed {
      key_type  record_key;
      seq_type  sequence_req;
      kind_type record_kind;
      tag_type  value_tag;
      logic     corrupt;
      logic     end_of_input;
   } req_item_type;

   typedef struct packed {
      key_type  out_key;
      seq_type  out_sequence;
      kind_type out_kind;
      tag_type  out_value_tag;
      logic     value_cleared;
      logic     error;
      logic     last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_IDX_BITS-1:0]  reg_index;
      logic [CSR_DATA_BITS-1:0] wdata;
   } csr_item_type;

endpackage

FILE: src/lsmf_req_if.sv
interface lsmf_req_if import lsmf_pkg::*;;
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

FILE: src/lsmf_rsp_if.sv
interface lsmf_rsp_if import lsmf_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

FILE: src/lsmf_csr_if.sv
interface lsmf_csr_if import lsmf_pkg::*;;
   logic         valid;
   logic         ready;
   csr_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

FILE: src/lsm_flush_record_filter.sv
// channel   dir   handshake            item
// req_ch    in    valid/ready          key, sequence, kind, value tag, corrupt, end
// rsp_ch    out   valid/ready          key, sequence, kind, tag, cleared, error, last
// csr_ch    in    valid/ready (ready=1) register index, write data
//
// an item goes into an input register, is settled there and its zero to two
// results land in a two-entry result buffer; while rsp_ch is ready it takes one
// item per cycle if each item gives at most one result and drains one result per
// cycle, and an item with two results holds the next back until one has drained
// reset is synchronous and clears the filter state flags, tracked key and stripe,
// the result count and the configuration registers; held delete fields load on use
// a stalled rsp_ch holds the input register, so req_ch stalls one item later
module lsm_flush_record_filter import lsmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lsmf_req_if.sink   req_ch,
   lsmf_rsp_if.source rsp_ch,
   lsmf_csr_if.sink   csr_ch
);

   // configuration registers
   seq_type              snap_ff [NUM_SNAP_REGS];
   logic [CNT_BITS-1:0]  snap_count_ff;
   seq_type              conflict_ff;
   logic                 keep_all_ff;

   // input register
   logic         in_vld_ff, in_vld_in;
   req_item_type in_ff;

   // filter state
   logic    have_key_ff, have_key_in;
   key_type tracked_key_ff, tracked_key_in;
   seq_type tracked_stripe_ff, tracked_stripe_in;
   logic    key_emitted_ff, key_emitted_in;
   logic    held_valid_ff, held_valid_in;
   key_type held_key_ff, held_key_in;
   seq_type held_seq_ff, held_seq_in;
   seq_type held_prev_ff, held_prev_in;
   tag_type held_tag_ff, held_tag_in;
   logic    failed_ff, failed_in;

   // result buffer
   rsp_item_type slot0_ff, slot0_in;
   rsp_item_type slot1_ff, slot1_in;
   logic [1:0]   cnt_ff, cnt_in;

   logic can_load, adv, pop, req_fire;

   // settle logic
   logic [CNT_BITS-1:0] cnt_sat;
   logic    found;
   seq_type stripe, prev;
   logic    emit_h, do_proc, clr, err_res, proc_emit, new_key, has_second;
   seq_type last;
   rsp_item_type held_rec, proc_rec, err_rec, second_rec, res0, res1;
   logic [1:0] n_res;

   // handshakes
   assign pop          = (cnt_ff != 2'd0) && rsp_ch.ready;
   assign can_load     = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);
   assign adv          = in_vld_ff && can_load;
   assign req_ch.ready = !in_vld_ff || can_load;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_ch.item  = slot0_ff;
   assign csr_ch.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SNAP_REGS; i++) begin
            snap_ff[i] <= '0;
         end
         snap_count_ff <= '0;
         conflict_ff   <= '0;
         keep_all_ff   <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.item.reg_index)
            CSR_SNAPSHOT_A:    snap_ff[0]    <= csr_ch.item.wdata[SEQ_BITS-1:0];
            CSR_SNAPSHOT_B:    snap_ff[1]    <= csr_ch.item.wdata[SEQ_BITS-1:0];
            CSR_SNAPSHOT_C:    snap_ff[2]    <= csr_ch.item.wdata[SEQ_BITS-1:0];
            CSR_SNAPSHOT_D:    snap_ff[3]    <= csr_ch.item.wdata[SEQ_BITS-1:0];
            CSR_SNAPSHOT_CNT:  snap_count_ff <= csr_ch.item.wdata[CNT_BITS-1:0];
            CSR_CONFLICT_SNAP: conflict_ff   <= csr_ch.item.wdata[SEQ_BITS-1:0];
            CSR_KEEP_ALL:      keep_all_ff   <= csr_ch.item.wdata[0];
            default: ;
         endcase
      end
   end

   // stripe lookup: first live snapshot at or above the sequence, else the tip
   always_comb begin
      cnt_sat = (snap_count_ff > CNT_BITS'(MAX_SNAPSHOTS)) ? CNT_BITS'(MAX_SNAPSHOTS)
                                                          : snap_count_ff;
      found  = 1'b0;
      stripe = MAX_SEQ;
      prev   = '0;
      for (int i = 0; i < NUM_SNAP_REGS; i++) begin
         if (!found && (CNT_BITS'(i) < cnt_sat)) begin
            if (snap_ff[i] >= in_ff.sequence_req) begin
               found  = 1'b1;
               stripe = snap_ff[i];
            end else begin
               prev = snap_ff[i];
            end
         end
      end
   end

   // settle the held single delete, then filter the record
   always_comb begin
      have_key_in       = have_key_ff;
      tracked_key_in    = tracked_key_ff;
      tracked_stripe_in = tracked_stripe_ff;
      key_emitted_in    = key_emitted_ff;
      held_valid_in     = held_valid_ff;
      held_key_in       = held_key_ff;
      held_seq_in       = held_seq_ff;
      held_prev_in      = held_prev_ff;
      held_tag_in       = held_tag_ff;
      failed_in         = failed_ff;
      emit_h    = 1'b0;
      do_proc   = 1'b0;
      clr       = 1'b0;
      err_res   = 1'b0;
      proc_emit = 1'b0;
      new_key   = 1'b0;
      last      = '0;

      if (!failed_ff) begin
         if (in_ff.end_of_input || in_ff.corrupt) begin
            if (held_valid_ff) begin
               emit_h      = 1'b1;
               have_key_in = 1'b0;
            end
            if (!in_ff.end_of_input) begin
               err_res   = 1'b1;
               failed_in = 1'b1;
            end
         end else if (!held_valid_ff) begin
            do_proc = 1'b1;
         end else if (in_ff.record_key != held_key_ff) begin
            emit_h      = 1'b1;
            have_key_in = 1'b0;
            do_proc     = 1'b1;
         end else if ((held_prev_ff == '0) || (in_ff.sequence_req > held_prev_ff)) begin
            if (in_ff.record_kind == KIND_SINGLE_DEL) begin
               held_valid_in = 1'b0;
               do_proc       = 1'b1;
            end else if ((held_seq_ff <= conflict_ff) || key_emitted_ff) begin
               // delete and its put cancel out
               held_valid_in = 1'b0;
            end else begin
               emit_h  = 1'b1;
               clr     = 1'b1;
               do_proc = 1'b1;
            end
         end else begin
            emit_h  = 1'b1;
            do_proc = 1'b1;
         end

         if (emit_h) begin
            held_valid_in  = 1'b0;
            key_emitted_in = 1'b1;
         end

         if (do_proc) begin
            new_key        = !have_key_in || (in_ff.record_key != tracked_key_ff);
            last           = new_key ? '0 : tracked_stripe_ff;
            tracked_key_in = in_ff.record_key;
            have_key_in    = 1'b1;
            if (new_key) begin
               key_emitted_in = 1'b0;
            end
            if (clr) begin
               tracked_stripe_in = stripe;
               proc_emit         = 1'b1;
            end else if (keep_all_ff) begin
               proc_emit = 1'b1;
            end else begin
               tracked_stripe_in = stripe;
               if (in_ff.record_kind == KIND_SINGLE_DEL) begin
                  held_valid_in = 1'b1;
                  held_key_in   = in_ff.record_key;
                  held_seq_in   = in_ff.sequence_req;
                  held_prev_in  = prev;
                  held_tag_in   = in_ff.value_tag;
               end else if (last != stripe) begin
                  proc_emit = 1'b1;
               end
            end
            if (proc_emit) begin
               key_emitted_in = 1'b1;
            end
         end
      end
   end

   // result assembly
   always_comb begin
      held_rec               = '0;
      held_rec.out_key       = held_key_ff;
      held_rec.out_sequence  = held_seq_ff;
      held_rec.out_kind      = KIND_SINGLE_DEL;
      held_rec.out_value_tag = held_tag_ff;

      proc_rec               = '0;
      proc_rec.out_key       = in_ff.record_key;
      proc_rec.out_sequence  = in_ff.sequence_req;
      proc_rec.out_kind      = in_ff.record_kind;
      proc_rec.out_value_tag = clr ? '0 : in_ff.value_tag;
      proc_rec.value_cleared = clr;

      err_rec       = '0;
      err_rec.error = 1'b1;

      second_rec = proc_emit ? proc_rec : err_rec;
      has_second = proc_emit || err_res;
      n_res      = {1'b0, emit_h} + {1'b0, has_second};

      res0 = '0;
      res1 = '0;
      if (emit_h) begin
         res0 = held_rec;
         res1 = second_rec;
         res1.last_of_run = 1'b1;
         res0.last_of_run = !has_second;
      end else begin
         res0 = second_rec;
         res0.last_of_run = 1'b1;
      end
   end

   // next values of the input register and the result buffer
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end

      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (adv) begin
         cnt_in   = n_res;
         slot0_in = res0;
         slot1_in = res1;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         cnt_ff            <= 2'd0;
         have_key_ff       <= 1'b0;
         tracked_key_ff    <= '0;
         tracked_stripe_ff <= '0;
         key_emitted_ff    <= 1'b0;
         held_valid_ff     <= 1'b0;
         failed_ff         <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
         if (adv) begin
            have_key_ff       <= have_key_in;
            tracked_key_ff    <= tracked_key_in;
            tracked_stripe_ff <= tracked_stripe_in;
            key_emitted_ff    <= key_emitted_in;
            held_valid_ff     <= held_valid_in;
            failed_ff         <= failed_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_ch.item;
      end
      if (adv) begin
         held_key_ff  <= held_key_in;
         held_seq_ff  <= held_seq_in;
         held_prev_ff <= held_prev_in;
         held_tag_ff  <= held_tag_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // a held delete always belongs to the tracked key
   a_held_tracked: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (have_key_ff && (tracked_key_ff == held_key_ff)))
      else $error("held delete without matching tracked key");

   // nothing comes out once the stream has failed
   a_failed_silent: assert property (@(posedge clock) disable iff (reset)
      (adv && failed_ff) |-> (n_res == 2'd0))
      else $error("result after failure");

   // an error result ends the stream
   a_error_fails: assert property (@(posedge clock) disable iff (reset)
      (adv && err_res) |=> failed_ff)
      else $error("error result without failure");

   // a cleared put always follows its emitted single delete
   a_cleared_pair: assert property (@(posedge clock) disable iff (reset)
      (adv && (n_res == 2'd2) && res1.value_cleared) |->
         (res0.out_kind == KIND_SINGLE_DEL))
      else $error("cleared put without preceding delete");

   // a full result buffer blocks a waiting item
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && (cnt_ff == 2'd2)) |-> !req_ch.ready)
      else $error("item accepted while result buffer full");

endmodule
